[hw/rtl/pnfb_pkg.sv]
// Shared types, coefficient tables and constants of the pink noise filter bank.
package pnfb_pkg;

  localparam int MAX_STAGES  = 6;
  localparam int STAGE_IDX_W = 3;
  localparam int CFG_W       = 3;
  localparam int WHITE_W     = 16;
  localparam int OUT_W       = 24;
  localparam int COEF_W      = 18;
  localparam int ACC_W       = 28;
  localparam int TOTAL_W     = 31;
  localparam int MUL_A_W     = 32;
  localparam int MUL_B_W     = COEF_W;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int WIDE_W      = PROD_W + 1;
  localparam int ACC_SHIFT   = 17;
  localparam int OUT_SHIFT   = 21;
  localparam int SCALE_ALIGN = 4;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Retention and input scale of each stage, signed Q0.17.
  localparam coef_t RETENTION_Q17 [MAX_STAGES] = '{
    18'sd130923, 18'sd130196, 18'sd127009, 18'sd113574, 18'sd72090, -18'sd99824
  };
  localparam coef_t SCALE_Q17 [MAX_STAGES] = '{
    18'sd7277, 18'sd9840, 18'sd20166, 18'sd40696, 18'sd69855, -18'sd2215
  };
  // Output gain 0.25/sqrt(n) for n active stages, signed Q0.17.
  localparam coef_t OUT_MULT_Q17 [MAX_STAGES] = '{
    18'sd32768, 18'sd23170, 18'sd18919, 18'sd16384, 18'sd14654, 18'sd13377
  };

  localparam logic [CFG_W-1:0] STAGE_COUNT_RESET = CFG_W'(MAX_STAGES);

  localparam logic signed [WIDE_W-1:0] ACC_ROUND = WIDE_W'(1) <<< (ACC_SHIFT - 1);
  localparam logic signed [WIDE_W-1:0] OUT_ROUND = WIDE_W'(1) <<< (OUT_SHIFT - 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_RET,
    ST_LAST,
    ST_OMUL,
    ST_ROUND
  } state_t;

  typedef enum logic [1:0] {
    MSEL_SCALE,
    MSEL_RET,
    MSEL_OUT
  } mul_sel_t;

  typedef struct packed {
    logic                   mul_en;
    mul_sel_t               mul_sel;
    logic [STAGE_IDX_W-1:0] op_idx;
    logic                   sum_load;
    logic                   fin_en;
    logic [STAGE_IDX_W-1:0] fin_idx;
    logic                   total_clr;
    logic                   out_load;
  } ctrl_t;

endpackage

[hw/rtl/pnfb_if.sv]
// Stream interfaces for the white noise input and the pink noise output.
interface pnfb_white_if;
  logic                             valid;
  logic                             ready;
  logic [pnfb_pkg::WHITE_W-1:0]     white_sample;

  modport source (output valid, output white_sample, input ready);
  modport sink (input valid, input white_sample, output ready);
endinterface

interface pnfb_pink_if;
  logic                             valid;
  logic                             ready;
  logic signed [pnfb_pkg::OUT_W-1:0] pink_sample;

  modport source (output valid, output pink_sample, input ready);
  modport sink (input valid, input pink_sample, output ready);
endinterface

[hw/rtl/pnfb_mult.sv]
// Shared signed multiplier with a registered product.
module pnfb_mult (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [pnfb_pkg::MUL_A_W-1:0] a,
  input  logic signed [pnfb_pkg::MUL_B_W-1:0] b,
  output logic signed [pnfb_pkg::PROD_W-1:0]  prod
);
  import pnfb_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

[hw/rtl/pnfb_ctrl.sv]
// Sequencer that steps the shared multiplier through the stages and the output gain.
module pnfb_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             out_free,
  input  logic [pnfb_pkg::STAGE_IDX_W-1:0] last_idx,
  output logic                             in_ready,
  output pnfb_pkg::ctrl_t                  ctl
);
  import pnfb_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [STAGE_IDX_W-1:0] stage;
  logic [STAGE_IDX_W-1:0] stage_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      stage <= '0;
    end else begin
      state <= state_next;
      stage <= stage_next;
    end
  end

  always_comb begin
    state_next = state;
    stage_next = stage;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCALE;
          stage_next = '0;
        end
      end
      ST_SCALE: state_next = ST_RET;
      ST_RET: begin
        if (stage == last_idx) begin
          state_next = ST_LAST;
        end else begin
          state_next = ST_SCALE;
          stage_next = stage + STAGE_IDX_W'(1);
        end
      end
      ST_LAST:  state_next = ST_OMUL;
      ST_OMUL:  state_next = ST_ROUND;
      ST_ROUND: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    ctl.mul_sel = MSEL_SCALE;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_ready      = !rst;
        ctl.total_clr = in_valid && !rst;
      end
      ST_SCALE: begin
        // The scale product of this stage overlaps the update of the previous one.
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_SCALE;
        ctl.op_idx  = stage;
        ctl.fin_en  = (stage != '0);
        ctl.fin_idx = stage - STAGE_IDX_W'(1);
      end
      ST_RET: begin
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = MSEL_RET;
        ctl.op_idx   = stage;
        ctl.sum_load = 1'b1;
      end
      ST_LAST: begin
        ctl.fin_en  = 1'b1;
        ctl.fin_idx = stage;
      end
      ST_OMUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MSEL_OUT;
      end
      ST_ROUND: ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

endmodule

[hw/rtl/pink_noise_filter_bank_unit.sv]
// Top level of the pink noise filter bank: configuration, accumulators and datapath.
//
// Usage: each beat on the white channel carries one unsigned Q0.16 white noise
// sample, and for each one exactly one signed Q7.16 pink sample leaves on the
// pink channel, in order. Both channels are valid/ready streams.
// The stage_count register (1..6, reset 6) is written through cfg_wr_en and
// cfg_wr_data; the user must write it only while the block is idle, which the
// block does not enforce itself. Values of 0 act as 1, and values above six or
// above NUM_FILTERS are limited. Changing it keeps the accumulators.
// One multiplier is shared by all the work: each active stage takes two
// multiplies (scale times white, then retention times accumulator), followed
// by one multiply for the output gain. A new white sample is accepted only
// when the block is idle, after the last one has gone through every stage
// and its result has been loaded into the output register.
// The result sits in an output register, so a new white sample is taken
// while a finished result still waits; if the receiver stalls, the block
// finishes the next sample and then holds it until the register frees.
// Synchronous reset clears the accumulators, empties the output register and
// sets stage_count to six.
module pink_noise_filter_bank_unit #(
  parameter int NUM_FILTERS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [pnfb_pkg::CFG_W-1:0]    cfg_wr_data,
  pnfb_white_if.sink                    white,
  pnfb_pink_if.source                   pink
);
  import pnfb_pkg::*;

  localparam int IDX_W = (NUM_FILTERS > 1) ? $clog2(NUM_FILTERS) : 1;
  localparam int SH_ACC_W = WIDE_W - ACC_SHIFT;
  localparam int SH_OUT_W = WIDE_W - OUT_SHIFT;

  logic [CFG_W-1:0]          stage_count;
  logic [STAGE_IDX_W-1:0]    active_n;
  logic [STAGE_IDX_W-1:0]    last_idx;
  logic [WHITE_W-1:0]        white_reg;
  logic signed [ACC_W-1:0]   acc [NUM_FILTERS];
  logic signed [TOTAL_W-1:0] total;
  logic signed [WIDE_W-1:0]  sum;
  logic signed [OUT_W-1:0]   pink_reg;
  logic                      out_valid;
  logic                      out_free;
  logic                      in_ready;
  ctrl_t                     ctl;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [WIDE_W-1:0]   upd_full;
  logic signed [SH_ACC_W-1:0] upd_shift;
  logic signed [ACC_W-1:0]    upd_sat;
  logic signed [WIDE_W-1:0]   out_full;
  logic signed [SH_OUT_W-1:0] out_shift;
  logic signed [OUT_W-1:0]    out_sat;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= STAGE_COUNT_RESET;
    end else if (cfg_wr_en) begin
      stage_count <= cfg_wr_data;
    end
  end

  // Active stage count: zero acts as one, then limit to six and to the bank size.
  always_comb begin
    priority if (stage_count == '0) begin
      active_n = STAGE_IDX_W'(1);
    end else if (stage_count > CFG_W'(MAX_STAGES)) begin
      active_n = STAGE_IDX_W'(MAX_STAGES);
    end else begin
      active_n = STAGE_IDX_W'(stage_count);
    end
    if (active_n > STAGE_IDX_W'(NUM_FILTERS)) begin
      active_n = STAGE_IDX_W'(NUM_FILTERS);
    end
    last_idx = active_n - STAGE_IDX_W'(1);
  end

  // The white sample is held for the whole stage sequence.
  always_ff @(posedge clk) begin
    if (white.valid && in_ready) begin
      white_reg <= white.white_sample;
    end
  end

  assign white.ready = in_ready;
  assign out_free    = !out_valid || pink.ready;

  pnfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (white.valid),
    .out_free (out_free),
    .last_idx (last_idx),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (ctl.mul_sel)
      MSEL_SCALE: begin
        mul_a = $signed({{(MUL_A_W-WHITE_W){1'b0}}, white_reg});
        mul_b = SCALE_Q17[ctl.op_idx];
      end
      MSEL_RET: begin
        mul_a = MUL_A_W'(acc[ctl.op_idx[IDX_W-1:0]]);
        mul_b = RETENTION_Q17[ctl.op_idx];
      end
      MSEL_OUT: begin
        mul_a = MUL_A_W'(total);
        mul_b = OUT_MULT_Q17[last_idx];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pnfb_mult u_mult (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // The scale product is kept, aligned from Q.33 to Q.37, while the
  // retention product is formed.
  always_ff @(posedge clk) begin
    if (ctl.sum_load) begin
      sum <= WIDE_W'(prod) <<< SCALE_ALIGN;
    end
  end

  // Stage update: round half up, floor to Q7.20 and saturate.
  always_comb begin
    upd_full  = sum + WIDE_W'(prod) + ACC_ROUND;
    upd_shift = SH_ACC_W'(upd_full >>> ACC_SHIFT);
    if (upd_shift > SH_ACC_W'(ACC_MAX)) begin
      upd_sat = ACC_MAX;
    end else if (upd_shift < SH_ACC_W'(ACC_MIN)) begin
      upd_sat = ACC_MIN;
    end else begin
      upd_sat = ACC_W'(upd_shift);
    end
  end

  // Output: round half up, floor to Q7.16 and saturate.
  always_comb begin
    out_full  = WIDE_W'(prod) + OUT_ROUND;
    out_shift = SH_OUT_W'(out_full >>> OUT_SHIFT);
    if (out_shift > SH_OUT_W'(OUT_MAX)) begin
      out_sat = OUT_MAX;
    end else if (out_shift < SH_OUT_W'(OUT_MIN)) begin
      out_sat = OUT_MIN;
    end else begin
      out_sat = OUT_W'(out_shift);
    end
  end

  // Accumulator bank; inactive stages keep their values.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_FILTERS; i++) begin
        acc[i] <= '0;
      end
    end else if (ctl.fin_en) begin
      acc[ctl.fin_idx[IDX_W-1:0]] <= upd_sat;
    end
  end

  // Running sum of the updated accumulators.
  always_ff @(posedge clk) begin
    if (ctl.total_clr) begin
      total <= '0;
    end else if (ctl.fin_en) begin
      total <= total + TOTAL_W'(upd_sat);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (pink.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      pink_reg <= out_sat;
    end
  end

  assign pink.valid       = out_valid;
  assign pink.pink_sample = pink_reg;

endmodule
